// ----- src/lsrc_pkg.sv -----
package lsrc_pkg;

  // unified memory depth in words; a power of two, indexes are the low address bits
  localparam int unsigned MEM_WORDS = 1024;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

  localparam int unsigned XLEN   = 32;
  localparam int unsigned PC_W   = 12;
  localparam int unsigned NREGS  = 32;
  localparam int unsigned RIDX_W = $clog2(NREGS);

  localparam logic [5:0] OPC_ADD  = 6'h00;
  localparam logic [5:0] OPC_ADDI = 6'h01;
  localparam logic [5:0] OPC_SUB  = 6'h02;
  localparam logic [5:0] OPC_SUBI = 6'h03;
  localparam logic [5:0] OPC_MUL  = 6'h04;
  localparam logic [5:0] OPC_MULI = 6'h05;
  localparam logic [5:0] OPC_OR   = 6'h06;
  localparam logic [5:0] OPC_ORI  = 6'h07;
  localparam logic [5:0] OPC_AND  = 6'h08;
  localparam logic [5:0] OPC_ANDI = 6'h09;
  localparam logic [5:0] OPC_XOR  = 6'h0A;
  localparam logic [5:0] OPC_XORI = 6'h0B;
  localparam logic [5:0] OPC_LDW  = 6'h0C;
  localparam logic [5:0] OPC_STW  = 6'h0D;
  localparam logic [5:0] OPC_BZ   = 6'h0E;
  localparam logic [5:0] OPC_BEQ  = 6'h0F;
  localparam logic [5:0] OPC_JR   = 6'h10;
  localparam logic [5:0] OPC_HALT = 6'h11;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_ARITH = 3'd1,
    KIND_LOGIC = 3'd2,
    KIND_MEM   = 3'd3,
    KIND_CTRL  = 3'd4
  } kind_e;

  typedef struct packed {
    logic              clr_we;
    logic [MEM_AW-1:0] clr_addr;
    logic              accept;
    logic              fetch;
    logic              exec;
    logic              wb_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic fetch_go;
  } dp_sts_t;

  function automatic logic [MEM_AW-1:0] mem_idx(input logic [XLEN-1:0] w);
    return w[MEM_AW-1:0];
  endfunction

endpackage

// ----- src/lsrc_item_if.sv -----
interface lsrc_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [9:0]  load_address;
  logic [31:0] load_data;

  modport source (output valid, output op, output load_address, output load_data,
                  input ready);
  modport sink (input valid, input op, input load_address, input load_data,
                output ready);
endinterface

// ----- src/lsrc_result_if.sv -----
interface lsrc_result_if;
  logic               valid;
  logic               ready;
  logic [11:0]        pc_after;
  logic               halted;
  logic [2:0]         kind;
  logic               branch_taken;
  logic               reg_written;
  logic [4:0]         reg_index;
  logic signed [31:0] reg_value;
  logic               mem_written;

  modport source (output valid, output pc_after, output halted, output kind,
                  output branch_taken, output reg_written, output reg_index,
                  output reg_value, output mem_written, input ready);
  modport sink (input valid, input pc_after, input halted, input kind,
                input branch_taken, input reg_written, input reg_index,
                input reg_value, input mem_written, output ready);
endinterface

// ----- src/lsrc_ram.sv -----
module lsrc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lsrc_ctrl.sv -----
module lsrc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  lsrc_pkg::dp_sts_t  sts_i,
  output lsrc_pkg::ctl_cmd_t cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;

  localparam logic [lsrc_pkg::MEM_AW-1:0] CLR_LAST =
    lsrc_pkg::MEM_AW'(lsrc_pkg::MEM_WORDS - 1);

  logic [2:0]                  state_q, state_d;
  logic [lsrc_pkg::MEM_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic                        wb_go;

  // writeback may only proceed when the output register is free or being drained
  assign wb_go = (state_q == ST_WB) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + lsrc_pkg::MEM_AW'(1);
        if (clr_cnt_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.fetch_go ? ST_FETCH : ST_WB;
        end
      end
      ST_FETCH: state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_WB;
      ST_WB: begin
        if (wb_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (wb_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.clr_we   = (state_q == ST_CLEAR);
    cmd_o.clr_addr = clr_cnt_q;
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.fetch    = (state_q == ST_FETCH);
    cmd_o.exec     = (state_q == ST_EXEC);
    cmd_o.wb_load  = wb_go;
  end

`ifndef ASSERT_OFF
  a_short_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && !sts_i.fetch_go) |=> (state_q == ST_WB))
    else $error("preload or halted item did not go straight to writeback");

  a_fetch_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |=> (state_q == ST_EXEC))
    else $error("fetch not followed by execute");

  a_wb_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB && (!out_valid_q || out_ready_i))
      |=> (state_q == ST_IDLE && out_valid_q))
    else $error("writeback did not post a result word");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !cmd_o.accept)
    else $error("item accepted during memory clear");
`endif

endmodule

// ----- src/lsrc_datapath.sv -----
module lsrc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsrc_pkg::ctl_cmd_t  cmd_i,
  output lsrc_pkg::dp_sts_t   sts_o,
  input  logic                op_i,
  input  logic [9:0]          load_address_i,
  input  logic [31:0]         load_data_i,
  output logic [11:0]         pc_after_o,
  output logic                halted_o,
  output logic [2:0]          kind_o,
  output logic                branch_taken_o,
  output logic                reg_written_o,
  output logic [4:0]          reg_index_o,
  output logic signed [31:0]  reg_value_o,
  output logic                mem_written_o
);

  localparam int unsigned AW = lsrc_pkg::MEM_AW;
  localparam int unsigned XL = lsrc_pkg::XLEN;
  localparam int unsigned RW = lsrc_pkg::RIDX_W;
  localparam int unsigned PW = lsrc_pkg::PC_W;

  // architectural state
  logic [PW-1:0]              pc_q;
  logic                       halt_q;
  logic [lsrc_pkg::NREGS-1:0] rf_vld_q;

  // per-item registers
  logic                       exe_q;
  logic [XL-1:0]              ir_q;
  logic [XL-1:0]              res_q;
  logic                       wr_q;
  logic [RW-1:0]              dst_q;
  logic [2:0]                 kind_q;
  logic                       taken_q;
  logic [PW-1:0]              next_q;
  logic                       hset_q;
  logic                       mwr_q;
  logic                       ld_q;

  // output word
  logic [PW-1:0]              pc_after_q;
  logic                       halted_q;
  logic [2:0]                 kind_out_q;
  logic                       taken_out_q;
  logic                       wr_out_q;
  logic [RW-1:0]              idx_out_q;
  logic [XL-1:0]              val_out_q;
  logic                       mwr_out_q;

  // memories
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [XL-1:0] mem_wdata, mem_rdata;
  logic          rf_we;
  logic [XL-1:0] rf_a_rdata, rf_b_rdata, wb_val;

  // decode and execute
  logic [5:0]    opc;
  logic [RW-1:0] rs, rt, rd;
  logic [XL-1:0] imm, a, b, opb, ea, prod;
  logic [XL-1:0] ex_res;
  logic          ex_wr, ex_taken, ex_halt, ex_mwr, ex_ld, ex_rdst;
  logic [2:0]    ex_kind;
  logic [PW-1:0] seq_pc, br_pc, ex_next;
  logic [RW-1:0] ex_dst;

  assign sts_o.fetch_go = op_i & ~halt_q;

  assign opc = ir_q[31:26];
  assign rs  = ir_q[25:21];
  assign rt  = ir_q[20:16];
  assign rd  = ir_q[15:11];
  assign imm = {{16{ir_q[15]}}, ir_q[15:0]};
  assign a   = rf_vld_q[rs] ? rf_a_rdata : '0;
  assign b   = rf_vld_q[rt] ? rf_b_rdata : '0;
  // odd ALU opcodes take the immediate
  assign opb  = opc[0] ? imm : b;
  assign ea   = a + imm;
  assign prod = a * opb;

  assign seq_pc = pc_q + PW'(4);
  assign br_pc  = pc_q + {ir_q[PW-3:0], 2'b00};

  always_comb begin
    ex_res   = '0;
    ex_wr    = 1'b0;
    ex_rdst  = 1'b1;
    ex_kind  = lsrc_pkg::KIND_NONE;
    ex_taken = 1'b0;
    ex_next  = seq_pc;
    ex_halt  = 1'b0;
    ex_mwr   = 1'b0;
    ex_ld    = 1'b0;
    case (opc)
      lsrc_pkg::OPC_ADD, lsrc_pkg::OPC_ADDI: begin
        ex_res  = a + opb;
        ex_wr   = 1'b1;
        ex_kind = lsrc_pkg::KIND_ARITH;
      end
      lsrc_pkg::OPC_SUB, lsrc_pkg::OPC_SUBI: begin
        ex_res  = a - opb;
        ex_wr   = 1'b1;
        ex_kind = lsrc_pkg::KIND_ARITH;
      end
      lsrc_pkg::OPC_MUL, lsrc_pkg::OPC_MULI: begin
        ex_res  = prod;
        ex_wr   = 1'b1;
        ex_kind = lsrc_pkg::KIND_ARITH;
      end
      lsrc_pkg::OPC_OR, lsrc_pkg::OPC_ORI: begin
        ex_res  = a | opb;
        ex_wr   = 1'b1;
        ex_kind = lsrc_pkg::KIND_LOGIC;
      end
      lsrc_pkg::OPC_AND, lsrc_pkg::OPC_ANDI: begin
        ex_res  = a & opb;
        ex_wr   = 1'b1;
        ex_kind = lsrc_pkg::KIND_LOGIC;
      end
      lsrc_pkg::OPC_XOR, lsrc_pkg::OPC_XORI: begin
        ex_res  = a ^ opb;
        ex_wr   = 1'b1;
        ex_kind = lsrc_pkg::KIND_LOGIC;
      end
      lsrc_pkg::OPC_LDW: begin
        ex_wr   = 1'b1;
        ex_ld   = 1'b1;
        ex_rdst = 1'b0;
        ex_kind = lsrc_pkg::KIND_MEM;
      end
      lsrc_pkg::OPC_STW: begin
        ex_mwr  = 1'b1;
        ex_kind = lsrc_pkg::KIND_MEM;
      end
      lsrc_pkg::OPC_BZ: begin
        ex_kind = lsrc_pkg::KIND_CTRL;
        if (a == '0) begin
          ex_taken = 1'b1;
          ex_next  = br_pc;
        end
      end
      lsrc_pkg::OPC_BEQ: begin
        ex_kind = lsrc_pkg::KIND_CTRL;
        if (a == b) begin
          ex_taken = 1'b1;
          ex_next  = br_pc;
        end
      end
      lsrc_pkg::OPC_JR: begin
        ex_kind  = lsrc_pkg::KIND_CTRL;
        ex_taken = 1'b1;
        ex_next  = {a[PW-3:0], 2'b00};
      end
      lsrc_pkg::OPC_HALT: begin
        ex_kind = lsrc_pkg::KIND_CTRL;
        ex_halt = 1'b1;
      end
      default: begin
        ex_kind = lsrc_pkg::KIND_NONE;
      end
    endcase
    // immediate forms write rt; writes to R0 are dropped
    if (opc[0]) begin
      ex_rdst = 1'b0;
    end
  end

  assign ex_dst = ex_rdst ? rd : rt;

  // unified memory port muxing: clear sweep, preload, store writes; fetch and load reads
  always_comb begin
    mem_we    = cmd_i.clr_we | (cmd_i.accept & ~op_i) | (cmd_i.exec & ex_mwr);
    mem_waddr = lsrc_pkg::mem_idx(ea);
    mem_wdata = b;
    if (cmd_i.clr_we) begin
      mem_waddr = cmd_i.clr_addr;
      mem_wdata = '0;
    end else if (cmd_i.accept) begin
      mem_waddr = lsrc_pkg::mem_idx({22'd0, load_address_i});
      mem_wdata = load_data_i;
    end
    mem_re    = (cmd_i.accept & sts_o.fetch_go) | (cmd_i.exec & ex_ld);
    mem_raddr = cmd_i.accept ? lsrc_pkg::mem_idx({22'd0, pc_q[PW-1:2]})
                             : lsrc_pkg::mem_idx(ea);
  end

  lsrc_ram #(
    .WIDTH(lsrc_pkg::XLEN),
    .DEPTH(lsrc_pkg::MEM_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign wb_val = ld_q ? mem_rdata : res_q;
  assign rf_we  = cmd_i.wb_load & exe_q & wr_q;

  // two copies of the register file give the rs and rt read ports
  lsrc_ram #(
    .WIDTH(lsrc_pkg::XLEN),
    .DEPTH(lsrc_pkg::NREGS)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (dst_q),
    .wdata_i (wb_val),
    .re_i    (cmd_i.fetch),
    .raddr_i (mem_rdata[25:21]),
    .rdata_o (rf_a_rdata)
  );

  lsrc_ram #(
    .WIDTH(lsrc_pkg::XLEN),
    .DEPTH(lsrc_pkg::NREGS)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (dst_q),
    .wdata_i (wb_val),
    .re_i    (cmd_i.fetch),
    .raddr_i (mem_rdata[20:16]),
    .rdata_o (rf_b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      halt_q   <= 1'b0;
      rf_vld_q <= '0;
    end else if (cmd_i.wb_load && exe_q) begin
      pc_q   <= next_q;
      halt_q <= halt_q | hset_q;
      if (wr_q) begin
        rf_vld_q[dst_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      exe_q <= sts_o.fetch_go;
    end
    if (cmd_i.fetch) begin
      ir_q <= mem_rdata;
    end
    if (cmd_i.exec) begin
      res_q   <= ex_res;
      wr_q    <= ex_wr && (ex_dst != '0);
      dst_q   <= ex_dst;
      kind_q  <= ex_kind;
      taken_q <= ex_taken;
      next_q  <= ex_next;
      hset_q  <= ex_halt;
      mwr_q   <= ex_mwr;
      ld_q    <= ex_ld;
    end
    if (cmd_i.wb_load) begin
      pc_after_q  <= exe_q ? next_q : pc_q;
      halted_q    <= halt_q | (exe_q & hset_q);
      kind_out_q  <= exe_q ? kind_q : lsrc_pkg::KIND_NONE;
      taken_out_q <= exe_q & taken_q;
      wr_out_q    <= exe_q & wr_q;
      idx_out_q   <= (exe_q && wr_q) ? dst_q : '0;
      val_out_q   <= (exe_q && wr_q) ? wb_val : '0;
      mwr_out_q   <= exe_q & mwr_q;
    end
  end

  assign pc_after_o     = pc_after_q;
  assign halted_o       = halted_q;
  assign kind_o         = kind_out_q;
  assign branch_taken_o = taken_out_q;
  assign reg_written_o  = wr_out_q;
  assign reg_index_o    = idx_out_q;
  assign reg_value_o    = $signed(val_out_q);
  assign mem_written_o  = mwr_out_q;

endmodule

// ----- src/load_store_risc_core.sv -----
// channel   dir  modport  payload
// item_i    in   sink     op, load_address, load_data
// result_o  out  source   pc_after, halted, kind, branch_taken, reg_written,
//                         reg_index, reg_value, mem_written
//
// An executed instruction goes through accept/fetch read, decode/register read,
// execute (memory access issued) and writeback; preloads and items while halted go
// from accept straight to writeback. One item at a time. After reset all MEM_WORDS
// memory words are swept to zero, ready held low. A result word waits in the output
// register; writeback stalls only while it is full and not being drained.
module load_store_risc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lsrc_item_if.sink            item_i,
  lsrc_result_if.source        result_o
);

  lsrc_pkg::ctl_cmd_t cmd;
  lsrc_pkg::dp_sts_t  sts;

  lsrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lsrc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (item_i.op),
    .load_address_i (item_i.load_address),
    .load_data_i    (item_i.load_data),
    .pc_after_o     (result_o.pc_after),
    .halted_o       (result_o.halted),
    .kind_o         (result_o.kind),
    .branch_taken_o (result_o.branch_taken),
    .reg_written_o  (result_o.reg_written),
    .reg_index_o    (result_o.reg_index),
    .reg_value_o    (result_o.reg_value),
    .mem_written_o  (result_o.mem_written)
  );

endmodule

// ----- tb/load_store_risc_core_tb.sv -----
module load_store_risc_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       WORD_PRELOAD  = 1'b0;
  localparam logic       WORD_EXEC     = 1'b1;
  localparam logic [5:0] OPC_UNUSED    = 6'h3F;
  localparam int unsigned RANDOM_WORDS = 600;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic                        op;
    logic [lsrc_pkg::MEM_AW-1:0] addr;
    logic [lsrc_pkg::XLEN-1:0]   data;
  } in_word_t;

  typedef struct packed {
    logic [lsrc_pkg::PC_W-1:0]          pc_after;
    logic                               halted;
    lsrc_pkg::kind_e                    kind;
    logic                               branch_taken;
    logic                               reg_written;
    logic [lsrc_pkg::RIDX_W-1:0]        reg_index;
    logic signed [lsrc_pkg::XLEN-1:0]   reg_value;
    logic                               mem_written;
  } out_word_t;

  logic clk_i;
  logic rst_ni;

  lsrc_item_if   item_bus ();
  lsrc_result_if result_bus ();

  load_store_risc_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  // architectural state of the core as seen through the result words
  logic [lsrc_pkg::XLEN-1:0] gpr     [lsrc_pkg::NREGS];
  logic [lsrc_pkg::XLEN-1:0] mem_img [lsrc_pkg::MEM_WORDS];
  logic [lsrc_pkg::PC_W-1:0] pc_q;
  logic                      halt_q;

  in_word_t  word_q[$];
  out_word_t retire_q[$];
  in_word_t  cur_word;

  int unsigned words_pushed, words_accepted, execs_accepted, results_seen;
  int unsigned mismatches, quiet_cycles;
  int unsigned src_gap_pct, sink_stall_pct;
  int unsigned hold_requests, holds_done, stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_word_t core_step(input in_word_t w);
    out_word_t r;
    logic [lsrc_pkg::XLEN-1:0] ins, a, b, imm, res, ea;
    logic [5:0] opc;
    logic [lsrc_pkg::RIDX_W-1:0] rs, rt, dst;
    logic [lsrc_pkg::PC_W-1:0] nxt;
    logic wr;
    r = '0;
    if (w.op == WORD_PRELOAD) begin
      mem_img[w.addr] = w.data;
    end else if (!halt_q) begin
      ins = mem_img[pc_q[lsrc_pkg::PC_W-1:2]];
      opc = ins[31:26];
      rs  = ins[25:21];
      rt  = ins[20:16];
      dst = ins[15:11];
      imm = {{16{ins[15]}}, ins[15:0]};
      a   = gpr[rs];
      b   = gpr[rt];
      ea  = a + imm;
      nxt = pc_q + 12'd4;
      res = '0;
      wr  = 1'b1;
      case (opc)
        lsrc_pkg::OPC_ADD: begin
          res = a + b;   r.kind = lsrc_pkg::KIND_ARITH;
        end
        lsrc_pkg::OPC_ADDI: begin
          res = a + imm; r.kind = lsrc_pkg::KIND_ARITH; dst = rt;
        end
        lsrc_pkg::OPC_SUB: begin
          res = a - b;   r.kind = lsrc_pkg::KIND_ARITH;
        end
        lsrc_pkg::OPC_SUBI: begin
          res = a - imm; r.kind = lsrc_pkg::KIND_ARITH; dst = rt;
        end
        lsrc_pkg::OPC_MUL: begin
          res = a * b;   r.kind = lsrc_pkg::KIND_ARITH;
        end
        lsrc_pkg::OPC_MULI: begin
          res = a * imm; r.kind = lsrc_pkg::KIND_ARITH; dst = rt;
        end
        lsrc_pkg::OPC_OR: begin
          res = a | b;   r.kind = lsrc_pkg::KIND_LOGIC;
        end
        lsrc_pkg::OPC_ORI: begin
          res = a | imm; r.kind = lsrc_pkg::KIND_LOGIC; dst = rt;
        end
        lsrc_pkg::OPC_AND: begin
          res = a & b;   r.kind = lsrc_pkg::KIND_LOGIC;
        end
        lsrc_pkg::OPC_ANDI: begin
          res = a & imm; r.kind = lsrc_pkg::KIND_LOGIC; dst = rt;
        end
        lsrc_pkg::OPC_XOR: begin
          res = a ^ b;   r.kind = lsrc_pkg::KIND_LOGIC;
        end
        lsrc_pkg::OPC_XORI: begin
          res = a ^ imm; r.kind = lsrc_pkg::KIND_LOGIC; dst = rt;
        end
        lsrc_pkg::OPC_LDW: begin
          res = mem_img[ea[lsrc_pkg::MEM_AW-1:0]];
          r.kind = lsrc_pkg::KIND_MEM;
          dst = rt;
        end
        lsrc_pkg::OPC_STW: begin
          mem_img[ea[lsrc_pkg::MEM_AW-1:0]] = b;
          r.kind = lsrc_pkg::KIND_MEM;
          r.mem_written = 1'b1;
          wr = 1'b0;
        end
        lsrc_pkg::OPC_BZ, lsrc_pkg::OPC_BEQ: begin
          r.kind = lsrc_pkg::KIND_CTRL;
          wr = 1'b0;
          // offset is relative to the branch itself, not pc+4
          if ((opc == lsrc_pkg::OPC_BZ) ? (a == '0) : (a == b)) begin
            r.branch_taken = 1'b1;
            nxt = pc_q + {imm[9:0], 2'b00};
          end
        end
        lsrc_pkg::OPC_JR: begin
          r.kind = lsrc_pkg::KIND_CTRL;
          r.branch_taken = 1'b1;
          nxt = {a[9:0], 2'b00};
          wr = 1'b0;
        end
        lsrc_pkg::OPC_HALT: begin
          r.kind = lsrc_pkg::KIND_CTRL;
          halt_q = 1'b1;
          wr = 1'b0;
        end
        default: wr = 1'b0;
      endcase
      if (wr && dst != '0) begin
        gpr[dst] = res;
        r.reg_written = 1'b1;
        r.reg_index = dst;
        r.reg_value = res;
      end
      pc_q = nxt;
    end
    r.pc_after = pc_q;
    r.halted = halt_q;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: got 0x%0h want 0x%0h",
                              results_seen, name, got, want));
  endtask

  // driver: one word in flight on the input channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_bus.valid <= 1'b0;
    end else begin
      if (item_bus.valid && item_bus.ready) begin
        retire_q.push_back(core_step(cur_word));
        words_accepted++;
        if (cur_word.op == WORD_EXEC) execs_accepted++;
      end
      if (!item_bus.valid || item_bus.ready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
          cur_word = word_q.pop_front();
          item_bus.valid        <= 1'b1;
          item_bus.op           <= cur_word.op;
          item_bus.load_address <= cur_word.addr;
          item_bus.load_data    <= cur_word.data;
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (retire_q.size() == 0) begin
          flag_mismatch($sformatf("result word %0d with nothing outstanding",
                                  results_seen));
        end else begin
          out_word_t want;
          want = retire_q.pop_front();
          check_field("pc_after", 32'(result_bus.pc_after), 32'(want.pc_after));
          check_field("halted", 32'(result_bus.halted), 32'(want.halted));
          check_field("kind", 32'(result_bus.kind), 32'(want.kind));
          check_field("branch_taken", 32'(result_bus.branch_taken),
                      32'(want.branch_taken));
          check_field("reg_written", 32'(result_bus.reg_written),
                      32'(want.reg_written));
          check_field("reg_index", 32'(result_bus.reg_index), 32'(want.reg_index));
          check_field("reg_value", result_bus.reg_value, want.reg_value);
          check_field("mem_written", 32'(result_bus.mem_written),
                      32'(want.mem_written));
        end
        results_seen++;
      end
      if (holds_done < hold_requests) begin
        holds_done++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d results outstanding",
               quiet_cycles, retire_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] insn(input logic [5:0] opc, input logic [4:0] rs,
                                       input logic [4:0] rt, input logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  // mostly the low registers, so results feed later instructions
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(9) < 7) ? 5'($urandom_range(7)) : 5'($urandom);
  endfunction

  function automatic logic [31:0] rand_insn();
    logic [5:0]  opc;
    logic [4:0]  rs, rt;
    logic [15:0] imm;
    if ($urandom_range(99) < 4) opc = 6'($urandom_range(63, lsrc_pkg::OPC_HALT + 1));
    else opc = 6'($urandom_range(lsrc_pkg::OPC_JR, lsrc_pkg::OPC_ADD));
    rs = pick_reg();
    rt = pick_reg();
    case ($urandom_range(3))
      0: imm = 16'($urandom);
      1: imm = 16'($urandom_range(16));
      2: imm = 16'hFFFF - 16'($urandom_range(15));
      default: imm = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endcase
    if (opc < lsrc_pkg::OPC_LDW && !opc[0]) imm[15:11] = pick_reg();
    if ((opc == lsrc_pkg::OPC_LDW || opc == lsrc_pkg::OPC_STW) && $urandom_range(1)) begin
      rs = 5'd0;
      imm = 16'($urandom_range(lsrc_pkg::MEM_WORDS - 1, lsrc_pkg::MEM_WORDS - 32));
    end
    if (opc == lsrc_pkg::OPC_BZ || opc == lsrc_pkg::OPC_BEQ) begin
      imm = 16'($urandom_range(6)) - 16'd3;
      if ($urandom_range(1)) rt = rs;
      if (opc == lsrc_pkg::OPC_BZ && $urandom_range(2) == 0) rs = 5'd0;
    end
    return insn(opc, rs, rt, imm);
  endfunction

  task automatic push_word(input logic op, input logic [lsrc_pkg::MEM_AW-1:0] addr,
                           input logic [31:0] data);
    in_word_t w;
    w.op = op;
    w.addr = addr;
    w.data = data;
    word_q.push_back(w);
    words_pushed++;
  endtask

  task automatic drain_words();
    while (words_accepted != words_pushed) @(posedge clk_i);
  endtask

  // program laid out at the current PC, then run; some runs are short of code
  task automatic run_segment(input bit with_hold);
    logic [lsrc_pkg::MEM_AW-1:0] at;
    logic [31:0] junk;
    int unsigned n_prog, n_exec, k;
    drain_words();
    at = pc_q[lsrc_pkg::PC_W-1:2];
    n_exec = $urandom_range(12, 3);
    case ($urandom_range(9))
      0: n_prog = 0;
      1: n_prog = $urandom_range(n_exec);
      default: n_prog = n_exec;
    endcase
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        junk = $urandom;
        // keep stray data from halting the core early
        if (junk[31:26] == lsrc_pkg::OPC_HALT) junk[26] = ~junk[26];
        push_word(WORD_PRELOAD, lsrc_pkg::MEM_AW'($urandom), junk);
      end
    end
    for (k = 0; k < n_prog; k++)
      push_word(WORD_PRELOAD, at + lsrc_pkg::MEM_AW'(k), rand_insn());
    repeat (n_exec) push_word(WORD_EXEC, lsrc_pkg::MEM_AW'($urandom), $urandom);
    if (with_hold) hold_requests++;
  endtask

  initial begin : stimulus
    logic [31:0] boot_prog [22];
    int unsigned dir_words, rnd_words, k;
    rst_ni = 1'b0;
    item_bus.valid = 1'b0;
    item_bus.op = WORD_PRELOAD;
    item_bus.load_address = '0;
    item_bus.load_data = '0;
    result_bus.ready = 1'b0;
    for (k = 0; k < lsrc_pkg::NREGS; k++) gpr[k] = '0;
    for (k = 0; k < lsrc_pkg::MEM_WORDS; k++) mem_img[k] = '0;
    pc_q = '0;
    halt_q = 1'b0;
    src_gap_pct = 12;
    sink_stall_pct = 78;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    boot_prog = '{
      insn(lsrc_pkg::OPC_ADDI, 5'd0, 5'd1, 16'hFFFF),
      insn(lsrc_pkg::OPC_ADDI, 5'd0, 5'd2, 16'h7FFF),
      insn(lsrc_pkg::OPC_MULI, 5'd2, 5'd3, 16'h8000),
      insn(lsrc_pkg::OPC_MUL,  5'd1, 5'd3, {5'd4, 11'd0}),
      insn(lsrc_pkg::OPC_SUB,  5'd0, 5'd1, {5'd5, 11'd0}),   // r5 = 0 - (-1)
      insn(lsrc_pkg::OPC_SUBI, 5'd1, 5'd6, 16'h8000),
      insn(lsrc_pkg::OPC_ADD,  5'd1, 5'd2, {5'd0, 11'd0}),   // dropped, dest is R0
      insn(lsrc_pkg::OPC_OR,   5'd1, 5'd2, {5'd7, 11'd0}),
      insn(lsrc_pkg::OPC_ORI,  5'd2, 5'd8, 16'h8000),
      insn(lsrc_pkg::OPC_AND,  5'd3, 5'd1, {5'd9, 11'd0}),
      insn(lsrc_pkg::OPC_ANDI, 5'd1, 5'd10, 16'h7FFF),
      insn(lsrc_pkg::OPC_XOR,  5'd1, 5'd2, {5'd11, 11'd0}),
      insn(lsrc_pkg::OPC_XORI, 5'd2, 5'd12, 16'hFFFF),
      insn(lsrc_pkg::OPC_STW,  5'd0, 5'd2, 16'h03FF),
      insn(lsrc_pkg::OPC_LDW,  5'd1, 5'd13, 16'h0400),  // -1 + 1024 wraps to the top word
      insn(OPC_UNUSED, 5'd31, 5'd31, 16'hFFFF),
      insn(lsrc_pkg::OPC_BZ,   5'd0, 5'd0, 16'd2),
      insn(lsrc_pkg::OPC_ADDI, 5'd0, 5'd14, 16'd1),
      insn(lsrc_pkg::OPC_BEQ,  5'd5, 5'd1, 16'hFFEE),   // 1 vs -1, falls through
      insn(lsrc_pkg::OPC_BEQ,  5'd1, 5'd1, 16'd1),
      insn(lsrc_pkg::OPC_BZ,   5'd1, 5'd0, 16'hFFFC),   // r1 nonzero, falls through
      insn(lsrc_pkg::OPC_JR,   5'd5, 5'd0, 16'd0)
    };
    push_word(WORD_PRELOAD, lsrc_pkg::MEM_AW'(lsrc_pkg::MEM_WORDS - 1), 32'hFFFF_FFFF);
    for (k = 0; k < 22; k++)
      push_word(WORD_PRELOAD, lsrc_pkg::MEM_AW'(k), boot_prog[k]);
    repeat (21) push_word(WORD_EXEC, '0, '0);
    dir_words = words_pushed;

    rnd_words = 0;
    while (rnd_words < RANDOM_WORDS) begin
      if (rnd_words < RANDOM_WORDS / 3) begin
        src_gap_pct = 12;
        sink_stall_pct = 78;
        run_segment(1'b0);
      end else if (rnd_words < 2 * RANDOM_WORDS / 3) begin
        src_gap_pct = 78;
        sink_stall_pct = 12;
        run_segment(1'b0);
      end else begin
        src_gap_pct = 0;
        sink_stall_pct = 0;
        run_segment(hold_requests == 0);
      end
      rnd_words = words_pushed - dir_words;
    end

    // halt last: afterwards only preloads change anything
    drain_words();
    push_word(WORD_PRELOAD, pc_q[lsrc_pkg::PC_W-1:2],
              insn(lsrc_pkg::OPC_HALT, 5'd0, 5'd0, 16'd0));
    repeat (3) push_word(WORD_EXEC, lsrc_pkg::MEM_AW'($urandom), $urandom);
    push_word(WORD_PRELOAD, lsrc_pkg::MEM_AW'(lsrc_pkg::MEM_WORDS - 1), 32'h0);
    push_word(WORD_EXEC, '0, '0);
    drain_words();
    while (retire_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words (%0d executed, %0d preloads), %0d results checked",
             words_accepted, execs_accepted, words_accepted - execs_accepted,
             results_seen);
    $display("every opcode plus unknown ones, R0 writes, wrapped loads/stores, "
             , "branches both ways, halt, three idle mixes and a long output hold");
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
